[rtl/dws_pkg.sv]
package dws_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = AW + 1;
  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SRCH = 2'b10
  } state_t;

endpackage

[rtl/dws_if.sv]
interface dws_req_if;
  logic                              valid;
  logic                              ready;
  logic        [dws_pkg::CMD_W-1:0]  cmd;
  logic signed [dws_pkg::VAL_W-1:0]  value;

  modport source(output valid, cmd, value, input ready);
  modport sink(input valid, cmd, value, output ready);
endinterface

interface dws_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [dws_pkg::ST_W-1:0]   status;
  logic                       found;

  modport source(output valid, status, found, input ready);
  modport sink(input valid, status, found, output ready);
endinterface

[rtl/dws_ram.sv]
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/deque_with_search.sv]
// Channel  Dir  Word fields              Handshake
// req      in   cmd[2:0], value[31:0]    valid / ready
// rsp      out  status[1:0], found       valid / ready
//
// Push, pop and unused commands finish in the accept cycle; the result word
// shows on rsp in the following cycle.
// A search walks the n held entries (at most DEPTH), stopping at a hit: the
// single read port of the entry RAM feeds one 32-bit comparator per cycle.
// Synchronous reset empties the deque at once; the RAM is not cleared.
// req is ready only while no search runs and the result register is free or
// being taken, so a stalled rsp holds off new words.
module deque_with_search (
  input  logic       clk,
  input  logic       rst,
  dws_req_if.sink    req,
  dws_rsp_if.source  rsp
);

  dws_pkg::state_t state;

  logic [dws_pkg::AW-1:0] front, front_next;
  logic [dws_pkg::CW-1:0] count, count_next;

  logic [dws_pkg::AW-1:0] rd_ptr;
  logic [dws_pkg::CW-1:0] iss_cnt;
  logic                   cmp_valid;
  logic [dws_pkg::VAL_W-1:0] key;

  logic              rsp_valid;
  dws_pkg::status_t  rsp_status, imm_status;
  logic              rsp_found;

  logic                      ram_we;
  logic [dws_pkg::AW-1:0]    ram_waddr;
  logic [dws_pkg::VAL_W-1:0] ram_rdata;

  logic                   accept, full, empty, issue, hit, done;
  logic [dws_pkg::SW-1:0] back_sum;
  logic [dws_pkg::AW-1:0] back_addr;

  assign req.ready  = (state == dws_pkg::S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign full       = (count == dws_pkg::CW'(dws_pkg::DEPTH));
  assign empty      = (count == '0);

  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.found  = rsp_found;

  // Back slot is front + count, which stays below twice the depth.
  assign back_sum  = dws_pkg::SW'(front) + dws_pkg::SW'(count);
  assign back_addr = (back_sum >= dws_pkg::SW'(dws_pkg::DEPTH)) ?
                     dws_pkg::AW'(back_sum - dws_pkg::SW'(dws_pkg::DEPTH)) :
                     dws_pkg::AW'(back_sum);

  always_comb begin
    front_next = front;
    count_next = count;
    ram_we     = 1'b0;
    ram_waddr  = back_addr;
    imm_status = dws_pkg::ST_DONE;
    case (dws_pkg::cmd_t'(req.cmd))
      dws_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          imm_status = dws_pkg::ST_FULL;
        end else begin
          front_next = (front == '0) ? dws_pkg::AW'(dws_pkg::DEPTH - 1) :
                       front - 1'b1;
          ram_we     = accept;
          ram_waddr  = front_next;
          count_next = count + 1'b1;
        end
      end
      dws_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          imm_status = dws_pkg::ST_FULL;
        end else begin
          ram_we     = accept;
          count_next = count + 1'b1;
        end
      end
      dws_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          imm_status = dws_pkg::ST_EMPTY;
        end else begin
          front_next = (front == dws_pkg::AW'(dws_pkg::DEPTH - 1)) ? '0 :
                       front + 1'b1;
          count_next = count - 1'b1;
        end
      end
      dws_pkg::CMD_POP_BACK: begin
        if (empty) begin
          imm_status = dws_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Search walk: one read issued per cycle, compared the cycle after.
  assign issue = (state == dws_pkg::S_SRCH) && (iss_cnt < count);
  assign hit   = cmp_valid && (ram_rdata == key);
  assign done  = (state == dws_pkg::S_SRCH) && (hit || (!issue && !cmp_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dws_pkg::S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      case (state)
        dws_pkg::S_IDLE: begin
          cmp_valid <= 1'b0;
          if (accept) begin
            if (dws_pkg::cmd_t'(req.cmd) == dws_pkg::CMD_SEARCH) begin
              state     <= dws_pkg::S_SRCH;
              rsp_valid <= 1'b0;
            end else begin
              front     <= front_next;
              count     <= count_next;
              rsp_valid <= 1'b1;
            end
          end else if (rsp.ready) begin
            rsp_valid <= 1'b0;
          end
        end
        dws_pkg::S_SRCH: begin
          if (done) begin
            state     <= dws_pkg::S_IDLE;
            rsp_valid <= 1'b1;
            cmp_valid <= 1'b0;
          end else begin
            cmp_valid <= issue;
          end
        end
        default: begin
          state <= dws_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key     <= req.value;
      rd_ptr  <= front;
      iss_cnt <= '0;
      if (dws_pkg::cmd_t'(req.cmd) != dws_pkg::CMD_SEARCH) begin
        rsp_status <= imm_status;
        rsp_found  <= 1'b0;
      end
    end else if (issue) begin
      rd_ptr  <= (rd_ptr == dws_pkg::AW'(dws_pkg::DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      iss_cnt <= iss_cnt + 1'b1;
    end
    if (done) begin
      rsp_status <= dws_pkg::ST_DONE;
      rsp_found  <= hit;
    end
  end

  dws_ram #(
    .WIDTH(dws_pkg::VAL_W),
    .DEPTH(dws_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.value),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

endmodule

[rtl/dws_chk.sv]
module dws_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [dws_pkg::ST_W-1:0]  rsp_status,
  input logic                      rsp_found
);

  // A result word waiting on the sink keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found))
    else $error("rsp word changed while stalled");

  // A new word is never taken while an earlier result still waits and is not being taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !rsp_valid || rsp_ready)
    else $error("req accepted over a pending result");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_status == dws_pkg::ST_DONE)
    else $error("found set with a non-done status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == dws_pkg::ST_DONE || rsp_status == dws_pkg::ST_FULL ||
                  rsp_status == dws_pkg::ST_EMPTY)
    else $error("unknown status code");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown right after reset");

endmodule

bind deque_with_search dws_chk u_dws_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_status(rsp.status),
  .rsp_found (rsp.found)
);
